@@ rtl/core/fan_curve_speed_lookup_assert.svh @@
// ----------------------------------------------------------------------------
// fan curve speed lookup assertion macros
// clocked on clk, held off while rst is high
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_SPEED_LOOKUP_ASSERT_SVH
`define FAN_CURVE_SPEED_LOOKUP_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define FCSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fcsl check failed in the same cycle");

// consequent checked in the cycle after the antecedent
`define FCSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fcsl check failed one cycle later");

`endif

@@ rtl/core/fcsl_pkg.sv @@
// ----------------------------------------------------------------------------
// fcsl_pkg
// shared types and constants of the fan curve speed lookup
// ----------------------------------------------------------------------------
package fcsl_pkg;

  localparam int FANS    = 6;
  localparam int POINTS  = 6;
  localparam int SENSORS = 4;

  localparam int NPTS   = FANS * POINTS;
  localparam int ADDR_W = $clog2(NPTS);
  localparam int PT_W   = $clog2(POINTS);
  localparam int SENS_W = $clog2(SENSORS);

  localparam logic [2:0] GROUP_EXT = 3'd4;

  // configuration port
  localparam int APB_AW = 3;
  localparam logic [APB_AW-3:0] REG_EXT_TIMEOUT = '0;
  localparam logic [31:0] EXT_TIMEOUT_RST = 32'd10000;

  // divider
  localparam int DIV_STEPS = 32;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  typedef enum logic [2:0] {
    OP_POINT  = 3'd0,
    OP_SOURCE = 3'd1,
    OP_EXT    = 3'd2,
    OP_SENSOR = 3'd3,
    OP_EVAL   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PICK,
    S_LAST,
    S_SCAN,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  fan;
    logic [2:0]  point;
    logic [1:0]  sensor;
    logic [2:0]  group;
    logic [15:0] temp_value;
    logic [15:0] rpm_value;
    logic        present;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_fan;
    logic [15:0] speed;
    logic        have_temp;
  } result_t;

endpackage

@@ rtl/core/fcsl_ram.sv @@
// ----------------------------------------------------------------------------
// fcsl_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fcsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/fcsl_div.sv @@
// ----------------------------------------------------------------------------
// fcsl_div
// restoring divider, one quotient bit per cycle, 32 by 16 bits
// ----------------------------------------------------------------------------
module fcsl_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);

  logic [31:0]                 q_sh;
  logic [15:0]                 rem;
  logic [fcsl_pkg::DIV_CW-1:0] count;
  logic [16:0]                 rem_sh;
  logic [16:0]                 diff;
  logic                        ge;

  assign rem_sh = {rem, q_sh[31]};
  assign diff   = rem_sh - {1'b0, divisor};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else if (start) begin
      count <= fcsl_pkg::DIV_CW'(fcsl_pkg::DIV_STEPS);
      done  <= 1'b0;
    end else if (count != '0) begin
      count <= count - 1'b1;
      done  <= (count == fcsl_pkg::DIV_CW'(1));
    end else begin
      done  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_sh <= dividend;
      rem  <= '0;
    end else if (count != '0) begin
      q_sh <= {q_sh[30:0], ge};
      rem  <= ge ? diff[15:0] : rem_sh[15:0];
    end
  end

  // quotient never exceeds the rpm step, so the upper half stays zero
  assign quotient = q_sh[15:0];

endmodule

@@ rtl/core/fan_curve_speed_lookup.sv @@
// ----------------------------------------------------------------------------
// fan_curve_speed_lookup
// per-fan piecewise linear temperature to rpm curve with source selection
// ----------------------------------------------------------------------------
// A write item (curve point, source, external or local temperature) is taken
// on accept and busy stays low. An evaluate item raises busy and goes straight
// to the result when no temperature is found or the fan is out of range, else a
// source pick, a read of the last point, a serial scan of up to POINTS curve
// points through the single ram read port, one multiply and a 32-step
// restoring divider that dominates the interpolating case. The result shows
// on done for exactly one cycle, in the last busy cycle, and cannot be held
// off by the receiver. Curve points read as zero until written.
module fan_curve_speed_lookup (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fcsl_pkg::in_item_t            item,
  output logic                          done,
  output fcsl_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcsl_pkg::APB_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  fcsl_pkg::state_t   state;
  fcsl_pkg::state_t   state_next;
  fcsl_pkg::in_item_t it;

  logic [31:0] ext_timeout;
  logic [2:0]  source_group [fcsl_pkg::FANS];
  logic [15:0] ext_temps    [fcsl_pkg::FANS];
  logic [31:0] ext_stamp;
  logic [15:0] sens_temps   [fcsl_pkg::SENSORS];
  logic [fcsl_pkg::SENSORS-1:0] sens_present;
  logic [fcsl_pkg::NPTS-1:0]    pt_valid;

  logic                        accept;
  logic                        wr_fan_ok;
  logic                        pt_we;
  logic [fcsl_pkg::ADDR_W-1:0] pt_waddr;
  logic [fcsl_pkg::ADDR_W-1:0] rd_addr;
  logic [fcsl_pkg::ADDR_W-1:0] base;
  logic [31:0]                 rd_q;
  logic                        rd_valid;
  logic [15:0]                 cur_t;
  logic [15:0]                 cur_r;

  logic [2:0]  fan_idx;
  logic        fan_ok;
  logic [2:0]  grp;
  logic [31:0] ext_age;
  logic        pick_found;
  logic [15:0] pick_t;

  logic [15:0]               tsel;
  logic                      found_r;
  logic [15:0]               speed_r;
  logic                      at_top;
  logic [fcsl_pkg::PT_W-1:0] cnt;
  logic [15:0]               prev_t;
  logic [15:0]               prev_r;
  logic [15:0]               dx;
  logic [15:0]               span;
  logic [15:0]               dy_mag;
  logic                      dy_neg;
  logic [31:0]               prod;

  logic scan_adv;
  logic scan_ret;
  logic div_start;
  logic div_done;
  logic [15:0] div_q;

  assign accept = start && !busy;
  assign wr_fan_ok = item.fan < 3'(fcsl_pkg::FANS);
  assign pt_we = accept && item.op == fcsl_pkg::OP_POINT && wr_fan_ok &&
                 item.point < 3'(fcsl_pkg::POINTS);
  assign pt_waddr = fcsl_pkg::ADDR_W'(item.fan * fcsl_pkg::POINTS + item.point);

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[fcsl_pkg::APB_AW-1:2] == fcsl_pkg::REG_EXT_TIMEOUT) ?
                  ext_timeout : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ext_timeout <= fcsl_pkg::EXT_TIMEOUT_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[fcsl_pkg::APB_AW-1:2] == fcsl_pkg::REG_EXT_TIMEOUT) begin
      ext_timeout <= pwdata;
    end
  end

  // item state written on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < fcsl_pkg::FANS; f++) begin
        source_group[f] <= '0;
        ext_temps[f]    <= '0;
      end
      for (int s = 0; s < fcsl_pkg::SENSORS; s++) begin
        sens_temps[s] <= '0;
      end
      sens_present <= '0;
      ext_stamp    <= '0;
      pt_valid     <= '0;
    end else if (accept) begin
      unique case (item.op)
        fcsl_pkg::OP_POINT: begin
          if (pt_we) begin
            pt_valid[pt_waddr] <= 1'b1;
          end
        end
        fcsl_pkg::OP_SOURCE: begin
          if (wr_fan_ok) begin
            source_group[item.fan] <= item.group;
          end
        end
        fcsl_pkg::OP_EXT: begin
          if (wr_fan_ok) begin
            ext_temps[item.fan] <= item.temp_value;
            ext_stamp           <= item.now_ms;
          end
        end
        fcsl_pkg::OP_SENSOR: begin
          if (32'(item.sensor) < fcsl_pkg::SENSORS) begin
            sens_temps[item.sensor]   <= item.temp_value;
            sens_present[item.sensor] <= item.present;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      it <= item;
    end
  end

  fcsl_ram #(
    .WIDTH(32),
    .DEPTH(fcsl_pkg::NPTS)
  ) u_pts (
    .clk  (clk),
    .we   (pt_we),
    .waddr(pt_waddr),
    .wdata({item.temp_value, item.rpm_value}),
    .raddr(rd_addr),
    .rdata(rd_q)
  );

  always_ff @(posedge clk) begin
    rd_valid <= pt_valid[rd_addr];
  end

  // unwritten points read as zero
  assign cur_t = rd_valid ? rd_q[31:16] : 16'd0;
  assign cur_r = rd_valid ? rd_q[15:0]  : 16'd0;

  // temperature source pick
  assign fan_ok  = it.fan < 3'(fcsl_pkg::FANS);
  assign fan_idx = fan_ok ? it.fan : 3'd0;
  assign grp     = source_group[fan_idx];
  assign ext_age = it.now_ms - ext_stamp;
  assign base    = fcsl_pkg::ADDR_W'(fan_idx * fcsl_pkg::POINTS);

  always_comb begin
    pick_found = 1'b0;
    pick_t     = '0;
    if (grp == fcsl_pkg::GROUP_EXT && ext_age < ext_timeout) begin
      pick_found = 1'b1;
      pick_t     = ext_temps[fan_idx];
    end else if (32'(grp) < fcsl_pkg::SENSORS &&
                 sens_present[grp[fcsl_pkg::SENS_W-1:0]]) begin
      pick_found = 1'b1;
      pick_t     = sens_temps[grp[fcsl_pkg::SENS_W-1:0]];
    end else begin
      // walk down so the lowest present sensor wins
      for (int s = fcsl_pkg::SENSORS - 1; s >= 0; s--) begin
        if (sens_present[s]) begin
          pick_found = 1'b1;
          pick_t     = sens_temps[s];
        end
      end
    end
  end

  // scan decisions on the point that just arrived
  assign scan_adv = tsel > cur_t;
  assign scan_ret = !scan_adv && (cnt == '0 || cur_t <= prev_t);

  fcsl_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (span),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcsl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fcsl_pkg::S_IDLE: begin
        if (accept && item.op == fcsl_pkg::OP_EVAL) begin
          state_next = fcsl_pkg::S_PICK;
        end
      end
      fcsl_pkg::S_PICK: begin
        state_next = (fan_ok && pick_found) ? fcsl_pkg::S_LAST : fcsl_pkg::S_DONE;
      end
      // the first point is still checked, the low clamp comes first
      fcsl_pkg::S_LAST:  state_next = fcsl_pkg::S_SCAN;
      fcsl_pkg::S_SCAN: begin
        priority if (scan_adv && !at_top) begin
          state_next = fcsl_pkg::S_SCAN;
        end else if (scan_adv || scan_ret) begin
          state_next = fcsl_pkg::S_DONE;
        end else begin
          state_next = fcsl_pkg::S_MUL;
        end
      end
      fcsl_pkg::S_MUL:   state_next = fcsl_pkg::S_DLOAD;
      fcsl_pkg::S_DLOAD: state_next = fcsl_pkg::S_DIV;
      fcsl_pkg::S_DIV: begin
        if (div_done) begin
          state_next = fcsl_pkg::S_DONE;
        end
      end
      fcsl_pkg::S_DONE:  state_next = fcsl_pkg::S_IDLE;
      default:           state_next = fcsl_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_addr   = base;
    div_start = 1'b0;
    unique case (state)
      fcsl_pkg::S_PICK:  rd_addr = base + fcsl_pkg::ADDR_W'(fcsl_pkg::POINTS - 1);
      fcsl_pkg::S_SCAN:  rd_addr = base + fcsl_pkg::ADDR_W'(cnt) + 1'b1;
      fcsl_pkg::S_DLOAD: div_start = 1'b1;
      default: ;
    endcase
  end

  assign busy = state != fcsl_pkg::S_IDLE;
  assign done = state == fcsl_pkg::S_DONE;

  // evaluation datapath
  always_ff @(posedge clk) begin
    unique case (state)
      fcsl_pkg::S_PICK: begin
        found_r <= fan_ok && pick_found;
        tsel    <= pick_t;
        speed_r <= '0;
      end
      fcsl_pkg::S_LAST: begin
        if (tsel >= cur_t) begin
          speed_r <= cur_r;
        end
        at_top <= tsel >= cur_t;
        cnt    <= '0;
      end
      fcsl_pkg::S_SCAN: begin
        priority if (scan_adv && !at_top) begin
          prev_t <= cur_t;
          prev_r <= cur_r;
          cnt    <= cnt + 1'b1;
        end else if (scan_ret) begin
          speed_r <= cur_r;
        end else if (!scan_adv) begin
          dx     <= tsel - prev_t;
          span   <= cur_t - prev_t;
          dy_neg <= cur_r < prev_r;
          dy_mag <= (cur_r < prev_r) ? (prev_r - cur_r) : (cur_r - prev_r);
        end
      end
      fcsl_pkg::S_MUL: begin
        prod <= dx * dy_mag;
      end
      fcsl_pkg::S_DIV: begin
        if (div_done) begin
          speed_r <= dy_neg ? (prev_r - div_q) : (prev_r + div_q);
        end
      end
      default: ;
    endcase
  end

  assign result.out_fan   = it.fan;
  assign result.speed     = speed_r;
  assign result.have_temp = found_r;

endmodule

@@ rtl/core/fcsl_checker.sv @@
// ----------------------------------------------------------------------------
// fcsl_checker
// port level checks of the fan curve speed lookup, bound to the top level
// ----------------------------------------------------------------------------
`include "fan_curve_speed_lookup_assert.svh"

module fcsl_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input fcsl_pkg::in_item_t item,
  input logic               done,
  input fcsl_pkg::result_t  result
);

  // an evaluate item holds the block until its result
  `FCSL_ASSERT_NEXT(a_eval_busy, start && !busy && item.op == fcsl_pkg::OP_EVAL, busy)

  // write items complete at once and give no result
  `FCSL_ASSERT_NEXT(a_write_quick, start && !busy && item.op != fcsl_pkg::OP_EVAL, !busy && !done)

  // a result closes the busy window
  `FCSL_ASSERT_NEXT(a_done_frees, done, !busy && !done)

  // no temperature means zero speed
  `FCSL_ASSERT_NOW(a_no_temp_zero, done && !result.have_temp, result.speed == 16'd0)

endmodule

bind fan_curve_speed_lookup fcsl_checker u_fcsl_checker (.*);
